/* hdl/hcrle_pkg.sv */
// Shared types and constants for the height-map column run-length encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcrle_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_MAX_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_LEVEL_COUNT  = 3'd2;
    localparam logic [2:0] REG_DEFAULT_TYPE = 3'd3;
    localparam logic [2:0] REG_LEVEL_WORD_0 = 3'd4;
    localparam logic [2:0] REG_LEVEL_WORD_3 = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int LEVEL_W     = 24;

    // Noise offset of +2.0 in Q3.12
    localparam logic signed [16:0] Q_TWO = 17'sd8192;

    // Air runs carry this code
    localparam logic [7:0] AIR_CODE = 8'd0;

    // Longest run one word can carry
    localparam logic [5:0] RUN_MAX = 6'd63;

    // Classified-sample queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic signed [15:0] min_height;
        logic signed [15:0] max_height;
        logic [2:0]         level_count;
        logic [7:0]         default_type;
    } cfg_t;

    typedef struct packed {
        logic       air;
        logic [7:0] code;
        logic       eor;
    } cls_t;

    typedef struct packed {
        logic valid;
        cls_t item;
    } push_t;

endpackage

`default_nettype wire

/* hdl/hcrle_fifo.sv */
// Four-word queue of classified samples between front and back.
// Depends on hcrle_pkg.
`default_nettype none

module hcrle_fifo
    import hcrle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire push_t             push,
    input  wire logic              pop,
    output cls_t                   head,
    output logic [QCNT_W-1:0]      count
);

    cls_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.valid) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

/* hdl/hcrle_front.sv */
// Front end: accept samples, map height, classify air/solid, pick block code.
// Depends on hcrle_pkg; feeds hcrle_fifo.
`default_nettype none

module hcrle_front
    import hcrle_pkg::*;
#(
    parameter int LEVEL_SLOTS = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic [LEVEL_W-1:0] level_word [LEVEL_SLOTS],
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] height_sample,
    input  wire logic signed [15:0] row_level,
    input  wire logic               end_of_row,
    input  wire logic [QCNT_W-1:0]  queue_count,
    output push_t                   push
);

    logic                     accept;
    logic signed [16:0]       sample_ofs;
    logic signed [16:0]       span;
    logic signed [16:0]       level_ofs;
    logic signed [33:0]       prod;
    logic signed [33:0]       rhs;
    logic                     found;
    logic signed [15:0]       best;
    logic signed [15:0]       start;
    logic [7:0]               code;

    logic                     s1_valid_reg;
    logic signed [33:0]       s1_prod_reg;
    logic signed [33:0]       s1_rhs_reg;
    logic [7:0]               s1_code_reg;
    logic                     s1_eor_reg;

    // Hold off while the queue could not take everything in flight
    assign in_ready = (queue_count + QCNT_W'(s1_valid_reg)) < QCNT_W'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sample_ofs = {height_sample[15], height_sample} + Q_TWO;
        span       = {cfg.max_height[15], cfg.max_height}
                   - {cfg.min_height[15], cfg.min_height};
        level_ofs  = {row_level[15], row_level} - {cfg.min_height[15], cfg.min_height};
        prod       = sample_ofs * span;
        rhs        = $signed({{4{level_ofs[16]}}, level_ofs, 13'd0});
    end

    // Highest level start not above the row; lowest slot wins ties
    always_comb
    begin
        found = 1'b0;
        best  = '0;
        start = '0;
        code  = cfg.default_type;
        for (int i = 0; i < LEVEL_SLOTS; i++)
        begin
            start = $signed(level_word[i][23:8]);
            if ((3'(i) < cfg.level_count) && (start <= row_level)
                && (!found || (start > best)))
            begin
                found = 1'b1;
                best  = start;
                code  = level_word[i][7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prod_reg <= prod;
            s1_rhs_reg  <= rhs;
            s1_code_reg <= code;
            s1_eor_reg  <= end_of_row;
        end
    end

    always_comb
    begin
        push.valid     = s1_valid_reg;
        push.item.air  = s1_prod_reg < s1_rhs_reg;
        push.item.code = push.item.air ? AIR_CODE : s1_code_reg;
        push.item.eor  = s1_eor_reg;
    end

endmodule

`default_nettype wire

/* hdl/hcrle_back.sv */
// Back end: merge classified samples into runs and drive the output register.
// Depends on hcrle_pkg; drains hcrle_fifo.
`default_nettype none

module hcrle_back
    import hcrle_pkg::*;
#(
    parameter int ROW_LENGTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cls_t              head,
    input  wire logic [QCNT_W-1:0] queue_count,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             block_code,
    output logic [5:0]             run_length,
    output logic                   row_done
);

    localparam int COL_W = $clog2(ROW_LENGTH + 1);

    logic             run_open_reg;
    logic             run_open_next;
    logic             run_is_air_reg;
    logic             run_is_air_next;
    logic [7:0]       run_type_reg;
    logic [7:0]       run_type_next;
    logic [5:0]       run_count_reg;
    logic [5:0]       run_count_next;
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       block_code_reg;
    logic [7:0]       block_code_next;
    logic [5:0]       run_length_reg;
    logic [5:0]       run_length_next;
    logic             row_done_reg;
    logic             row_done_next;

    logic             fire;
    logic             close;
    logic             row_end;
    logic [COL_W-1:0] col_inc;
    logic             emit;

    always_comb
    begin
        fire    = (queue_count != '0) && (!out_valid_reg || out_ready);
        close   = run_open_reg && ((head.air != run_is_air_reg)
                  || (head.code != run_type_reg) || (run_count_reg == RUN_MAX));
        col_inc = col_count_reg + 1'b1;
        row_end = head.eor || (col_inc >= COL_W'(ROW_LENGTH));

        pop             = 1'b0;
        emit            = 1'b0;
        block_code_next = block_code_reg;
        run_length_next = run_length_reg;
        row_done_next   = row_done_reg;
        run_open_next   = run_open_reg;
        run_is_air_next = run_is_air_reg;
        run_type_next   = run_type_reg;
        run_count_next  = run_count_reg;
        col_count_next  = col_count_reg;

        if (fire)
        begin
            if (close && row_end)
            begin
                // Close the old run only; keep the word for the row's final run
                emit            = 1'b1;
                block_code_next = run_type_reg;
                run_length_next = run_count_reg;
                row_done_next   = 1'b0;
                run_open_next   = 1'b0;
            end
            else
            begin
                pop = 1'b1;
                if (close)
                begin
                    emit            = 1'b1;
                    block_code_next = run_type_reg;
                    run_length_next = run_count_reg;
                    row_done_next   = 1'b0;
                end
                if (close || !run_open_reg)
                begin
                    run_is_air_next = head.air;
                    run_type_next   = head.code;
                    run_count_next  = 6'd1;
                end
                else
                begin
                    run_count_next = run_count_reg + 1'b1;
                end
                run_open_next  = 1'b1;
                col_count_next = col_inc;
                if (row_end)
                begin
                    emit            = 1'b1;
                    block_code_next = run_type_next;
                    run_length_next = run_count_next;
                    row_done_next   = 1'b1;
                    run_open_next   = 1'b0;
                    run_count_next  = '0;
                    col_count_next  = '0;
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg   <= 1'b0;
            run_is_air_reg <= 1'b0;
            run_type_reg   <= '0;
            run_count_reg  <= '0;
            col_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            run_open_reg   <= run_open_next;
            run_is_air_reg <= run_is_air_next;
            run_type_reg   <= run_type_next;
            run_count_reg  <= run_count_next;
            col_count_reg  <= col_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_code_reg <= block_code_next;
        run_length_reg <= run_length_next;
        row_done_reg   <= row_done_next;
    end

    assign out_valid  = out_valid_reg;
    assign block_code = block_code_reg;
    assign run_length = run_length_reg;
    assign row_done   = row_done_reg;

endmodule

`default_nettype wire

/* hdl/heightmap_column_run_length_encoder.sv */
// Height-map column run-length encoder, top level; uses hcrle_pkg, front, fifo, back.
// An accepted word goes through the front register and the queue to the output register;
// the row's final run takes a second back-end step when the same word closes the previous
// run. Throughput: one input word per cycle while the queue has room and out_ready allows;
// a word that closes a run and ends the row holds the back end while it emits both runs.
// The 4-word queue absorbs sparse ones; rows of two differing samples fall below that rate.
`default_nettype none

module heightmap_column_run_length_encoder
    import hcrle_pkg::*;
#(
    parameter int ROW_LENGTH  = 32,
    parameter int LEVEL_SLOTS = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // sample input
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [15:0]     height_sample,
    input  wire logic signed [15:0]     row_level,
    input  wire logic                   end_of_row,
    // run output
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  block_code,
    output logic [5:0]                  run_length,
    output logic                        row_done
);

    // Reset (rst_n, async, active low): empties pipeline and queue, closes any run,
    // and loads min 0, max 1, level count 0, default type 1, level words 0.

    cfg_t              cfg_reg;
    logic [LEVEL_W-1:0] level_word_reg [LEVEL_SLOTS];
    logic [1:0]        word_idx;

    push_t             push;
    cls_t              head;
    logic              pop;
    logic [QCNT_W-1:0] queue_count;

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block neither enforces this nor shadows. Level words beyond the built slots are dropped.
    assign word_idx = 2'(cfg_index - REG_LEVEL_WORD_0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_height   <= 16'sd0;
            cfg_reg.max_height   <= 16'sd1;
            cfg_reg.level_count  <= 3'd0;
            cfg_reg.default_type <= 8'd1;
            for (int i = 0; i < LEVEL_SLOTS; i++)
            begin
                level_word_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index) inside
                REG_MIN_HEIGHT:   cfg_reg.min_height   <= $signed(cfg_data[15:0]);
                REG_MAX_HEIGHT:   cfg_reg.max_height   <= $signed(cfg_data[15:0]);
                REG_LEVEL_COUNT:  cfg_reg.level_count  <= cfg_data[2:0];
                REG_DEFAULT_TYPE: cfg_reg.default_type <= cfg_data[7:0];
                [REG_LEVEL_WORD_0:REG_LEVEL_WORD_3]:
                begin
                    for (int i = 0; i < LEVEL_SLOTS; i++)
                    begin
                        if (word_idx == 2'(i))
                        begin
                            level_word_reg[i] <= cfg_data[LEVEL_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Front: one register stage holds the height product and the solid code;
    // the air/solid compare resolves as the word enters the queue.
    hcrle_front #(
        .LEVEL_SLOTS (LEVEL_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .level_word    (level_word_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .height_sample (height_sample),
        .row_level     (row_level),
        .end_of_row    (end_of_row),
        .queue_count   (queue_count),
        .push          (push)
    );

    // Queue decouples classification from run building
    hcrle_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (queue_count)
    );

    // Back: run state plus the output register; at most one result per cycle
    hcrle_back #(
        .ROW_LENGTH (ROW_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_count (queue_count),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .block_code  (block_code),
        .run_length  (run_length),
        .row_done    (row_done)
    );

    // Queue never overfills: front credit check must cover the in-flight word
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("classified-sample queue overfilled");

    // Every accepted sample reaches the queue in the next cycle
    a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> push.valid)
        else $error("accepted sample did not reach the queue");

    // Back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (queue_count != '0))
        else $error("pop from empty queue");

    // No run of zero length leaves the block
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length != 6'd0))
        else $error("zero-length run on output");

endmodule

`default_nettype wire

/* tb/hcrle_run_checker.sv */
`timescale 1ns / 1ps
// Run checker for the height-map column run-length encoder: tracks register writes,
// predicts run words from accepted samples and compares them with the output channel.
// Depends on hcrle_pkg for register indexes and constants.

module hcrle_run_checker
    import hcrle_pkg::*;
#(
    parameter int ROW_LEN = 32,
    parameter int SLOTS   = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic signed [15:0]     height_sample,
    input  wire logic signed [15:0]     row_level,
    input  wire logic                   end_of_row,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [7:0]             block_code,
    input  wire logic [5:0]             run_length,
    input  wire logic                   row_done,
    output int                          fail_count,
    output int                          runs_waiting
);

    typedef struct packed {
        logic [7:0] code;
        logic [5:0] len;
        logic       done;
    } run_word_t;

    // register copies
    logic signed [15:0] min_h;
    logic signed [15:0] max_h;
    logic [2:0]         lvl_count;
    logic [7:0]         dflt_code;
    logic [23:0]        lvl_word [4];

    // open run and column position
    logic       cur_open;
    logic       cur_air;
    logic [7:0] cur_code;
    int         cur_len;
    int         col;

    run_word_t  runs_due [$];

    // Highest terrain level whose start is not above the row level; first word wins ties.
    function automatic logic [7:0] solid_code_for(logic signed [15:0] lvl);
        int                 n;
        int                 i;
        logic               found;
        logic signed [15:0] best;
        logic signed [15:0] start;
        logic [7:0]         code;
        n     = (lvl_count > SLOTS) ? SLOTS : lvl_count;
        found = 1'b0;
        best  = '0;
        code  = dflt_code;
        for (i = 0; i < n; i++) begin
            start = lvl_word[i][23:8];
            if (start <= lvl && (!found || start > best)) begin
                found = 1'b1;
                best  = start;
                code  = lvl_word[i][7:0];
            end
        end
        return code;
    endfunction

    // Add one predicted run word at the tail of the expected list.
    function automatic void queue_run(logic [7:0] code, logic [5:0] len, logic done);
        run_word_t w;
        w.code = code;
        w.len  = len;
        w.done = done;
        runs_due.insert(runs_due.size(), w);
    endfunction

    function automatic void merge_sample(logic signed [15:0] v, logic signed [15:0] lvl,
                                         logic eor);
        longint     lhs;
        longint     rhs;
        logic       air;
        logic [7:0] code;
        // exact compare of the mapped height against the level, no rounding
        lhs  = (longint'(v) + longint'(Q_TWO)) * (longint'(max_h) - longint'(min_h));
        rhs  = (longint'(lvl) - longint'(min_h)) * longint'(Q_TWO);
        air  = lhs < rhs;
        code = air ? AIR_CODE : solid_code_for(lvl);
        if (cur_open && (air != cur_air || code != cur_code || cur_len >= RUN_MAX)) begin
            queue_run(cur_code, 6'(cur_len), 1'b0);
            cur_open = 1'b0;
        end
        if (!cur_open) begin
            cur_open = 1'b1;
            cur_air  = air;
            cur_code = code;
            cur_len  = 1;
        end else begin
            cur_len++;
        end
        col++;
        if (eor || col >= ROW_LEN) begin
            queue_run(cur_code, 6'(cur_len), 1'b1);
            cur_open = 1'b0;
            cur_len  = 0;
            col      = 0;
        end
    endfunction

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        run_word_t want;
        if (!rst_n) begin
            min_h        = 16'sd0;
            max_h        = 16'sd1;
            lvl_count    = '0;
            dflt_code    = 8'd1;
            lvl_word     = '{default: '0};
            cur_open     = 1'b0;
            cur_air      = 1'b0;
            cur_code     = '0;
            cur_len      = 0;
            col          = 0;
            runs_due.delete();
            fail_count   = 0;
            runs_waiting = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (runs_due.size() == 0) begin
                    $display({"%0t: unexpected run word, block_code %0d",
                              " run_length %0d row_done %0d"},
                             $time, block_code, run_length, row_done);
                    fail_count++;
                end else begin
                    want = runs_due.pop_front();
                    if (block_code !== want.code)
                        report_field("block_code", want.code, block_code);
                    if (run_length !== want.len)
                        report_field("run_length", 8'(want.len), 8'(run_length));
                    if (row_done !== want.done)
                        report_field("row_done", 8'(want.done), 8'(row_done));
                end
            end
            if (cfg_write) begin
                case (cfg_index)
                    REG_MIN_HEIGHT:   min_h = cfg_data[15:0];
                    REG_MAX_HEIGHT:   max_h = cfg_data[15:0];
                    REG_LEVEL_COUNT:  lvl_count = cfg_data[2:0];
                    REG_DEFAULT_TYPE: dflt_code = cfg_data[7:0];
                    default:          lvl_word[2'(cfg_index - REG_LEVEL_WORD_0)] = cfg_data;
                endcase
            end
            if (in_valid && in_ready)
                merge_sample(height_sample, row_level, end_of_row);
            runs_waiting = runs_due.size();
        end
    end

endmodule

/* tb/heightmap_column_run_length_encoder_test.sv */
`timescale 1ns / 1ps
// Testbench top for the height-map column run-length encoder: drives samples and
// register writes, throttles the run channel, and gives the verdict.
// Depends on hcrle_pkg, the encoder RTL and hcrle_run_checker.

module heightmap_column_run_length_encoder_test;
    import hcrle_pkg::*;

    localparam int ROW_LEN       = 32;
    localparam int SLOTS         = 4;
    localparam int LEVEL_WORDS   = 4;
    localparam int RANDOM_WORDS  = 1750;
    localparam int PHASES        = 7;
    // long receiver hold-off; far more than the queue and pipeline can absorb
    localparam int LONG_HOLD     = 300;
    // pipeline: front register, queue, output register; leave margin before touching registers
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [15:0]     height_sample;
    logic signed [15:0]     row_level;
    logic                   end_of_row;
    logic                   out_valid;
    logic                   out_ready;
    logic [7:0]             block_code;
    logic [5:0]             run_length;
    logic                   row_done;

    int fail_count;
    int runs_waiting;
    int words_sent    = 0;
    int cycles        = 0;
    // 0: random gaps, 1: back-to-back
    int src_mode      = 0;
    // 0: random stalls, 1: always ready
    int sink_mode     = 0;
    // bumped by the stimulus, consumed by the sink process
    int hold_requests = 0;
    // terrain height range of the current setting, used to aim row levels
    int cur_lo        = 0;
    int cur_hi        = 1;

    always #6 clk = ~clk;

    heightmap_column_run_length_encoder #(
        .ROW_LENGTH  (ROW_LEN),
        .LEVEL_SLOTS (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .height_sample (height_sample),
        .row_level     (row_level),
        .end_of_row    (end_of_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .block_code    (block_code),
        .run_length    (run_length),
        .row_done      (row_done)
    );

    hcrle_run_checker #(
        .ROW_LEN (ROW_LEN),
        .SLOTS   (SLOTS)
    ) run_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .height_sample (height_sample),
        .row_level     (row_level),
        .end_of_row    (end_of_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .block_code    (block_code),
        .run_length    (run_length),
        .row_done      (row_done),
        .fail_count    (fail_count),
        .runs_waiting  (runs_waiting)
    );

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return $urandom_range(15, 40);
        else if (roll < 8)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic int clamp16(int x);
        if (x < -32768)
            return -32768;
        if (x > 32767)
            return 32767;
        return x;
    endfunction

    // Row level somewhere inside the mapped height range, a little past either end.
    function automatic int pick_level();
        int a;
        int b;
        a = (cur_lo < cur_hi) ? cur_lo : cur_hi;
        b = (cur_lo < cur_hi) ? cur_hi : cur_lo;
        return clamp16(a + int'($urandom_range(0, b - a)) + int'($urandom_range(0, 128)) - 64);
    endfunction

    function automatic logic [23:0] level_word(int start, int code);
        return {16'(start), 8'(code)};
    endfunction

    // Receiver: one assignment to out_ready per edge. Once any running countdown ends, a
    // pending hold request wins and keeps the channel closed while LONG_HOLD counts down.
    initial begin : sink
        int   left;
        int   holds_served;
        logic rdy;
        left         = 0;
        holds_served = 0;
        rdy          = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (left > 0) begin
                left--;
            end else if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                rdy          = 1'b0;
                left         = LONG_HOLD;
            end else if (sink_mode == 1) begin
                rdy = 1'b1;
            end else begin
                rdy  = ($urandom_range(0, 2) != 0);
                left = rdy ? $urandom_range(0, 15) : idle_len();
            end
            out_ready <= rdy;
        end
    end

    // Watchdog: stop a hung run.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("heightmap_column_run_length_encoder_test: done, errors");
        $finish;
    end

    // Write one register; the caller lowers the write enable after the last one.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // Write every register; only called while the block is idle.
    task automatic apply_config(input int lo, input int hi, input int cnt, input int dflt,
                                input logic [23:0] w0, input logic [23:0] w1,
                                input logic [23:0] w2, input logic [23:0] w3);
        write_reg(REG_MIN_HEIGHT, 24'(lo));
        write_reg(REG_MAX_HEIGHT, 24'(hi));
        write_reg(REG_LEVEL_COUNT, 24'(cnt));
        write_reg(REG_DEFAULT_TYPE, 24'(dflt));
        write_reg(REG_LEVEL_WORD_0, w0);
        write_reg(REG_LEVEL_WORD_0 + 3'd1, w1);
        write_reg(REG_LEVEL_WORD_0 + 3'd2, w2);
        write_reg(REG_LEVEL_WORD_3, w3);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one sample word and hold it until accepted. Valid is only lowered when
    // a gap is taken, so back-to-back words never see a low-then-high in one step.
    task automatic send_word(input logic signed [15:0] v, input logic signed [15:0] lvl,
                             input logic eor);
        int gap;
        gap = (src_mode == 0) ? idle_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        height_sample <= v;
        row_level     <= lvl;
        end_of_row    <= eor;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Drop valid, wait for every predicted run word, then let the pipeline settle
    // so a sample that closes no run cannot be caught by a register write.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (runs_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One row: mostly a well-formed row built from a few sample values so that runs
    // form, sometimes longer than the row length; now and then raw noise words.
    task automatic random_row();
        int                 len;
        int                 i;
        int                 pick;
        logic signed [15:0] lvl;
        logic signed [15:0] v;
        logic signed [15:0] cand [3];
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++)
                send_word(16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
        end else begin
            len = (pick < 5) ? $urandom_range(32, 40) : $urandom_range(1, 31);
            lvl = 16'(pick_level());
            // samples between -2.5 and +0.5 span the whole mapped range and a bit more
            for (i = 0; i < 3; i++)
                cand[i] = 16'(int'($urandom_range(0, 12288)) - 10240);
            v = cand[0];
            for (i = 1; i <= len; i++) begin
                if ($urandom_range(0, 3) == 0)
                    v = cand[$urandom_range(0, 2)];
                // level change inside a row
                if ($urandom_range(0, 24) == 0)
                    lvl = 16'(pick_level());
                send_word(v, lvl, i == len);
            end
        end
    endtask

    initial begin : stimulus
        int          phase;
        int          target;
        int          i;
        int          cnt;
        int          dflt;
        logic [23:0] w [LEVEL_WORDS];

        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        height_sample <= '0;
        row_level     <= '0;
        end_of_row    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: min 0, max 1, no levels, default type 1.
        send_word(16'sd0, 16'sd1, 1'b0);
        send_word(-16'sd32768, 16'sd0, 1'b1);
        drain();

        // Heights -100..100, level count beyond the slots, code-zero level,
        // two levels with the same start, default type for levels below all starts.
        apply_config(-100, 100, 7, 8'hAB, level_word(-50, 8'h00), level_word(10, 8'h22),
                     level_word(10, 8'h33), level_word(50, 8'h44));
        send_word(-16'sd32768, -16'sd32768, 1'b0);
        send_word(-16'sd32768, -16'sd32768, 1'b0);
        send_word(16'sd32767, 16'sd32767, 1'b0);
        send_word(16'sd0, 16'sd0, 1'b0);
        // air right after a code-zero solid run: must split, then end the row
        send_word(-16'sd32768, 16'sd0, 1'b1);
        send_word(16'sd0, 16'sd10, 1'b0);
        send_word(16'sd0, 16'sd60, 1'b1);
        send_word(16'sd0, -16'sd60, 1'b1);
        drain();

        // Reversed range at the extremes: the map decreases with the sample.
        apply_config(32767, -32768, 2, 8'h00, level_word(-32768, 8'h11),
                     level_word(32767, 8'hFF), '0, '0);
        send_word(16'sd32767, 16'sd0, 1'b0);
        send_word(-16'sd32768, 16'sd0, 1'b0);
        send_word(-16'sd32768, 16'sd32767, 1'b1);
        send_word(-16'sd8192, -16'sd32768, 1'b1);
        drain();

        // Flat map: every sample maps to the same height.
        apply_config(5, 5, 1, 8'hFF, level_word(5, 8'h77), '0, '0, '0);
        send_word(16'sd0, 16'sd5, 1'b0);
        send_word(16'sd0, 16'sd6, 1'b0);
        send_word(16'sd0, 16'sd4, 1'b1);

        // Random part: one register setting per phase, the extremes among them.
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            src_mode  = 0;
            sink_mode = 0;
            dflt      = $urandom_range(0, 255);
            case (phase)
                1: begin
                    cur_lo = -32768;
                    cur_hi = 32767;
                    cnt    = 4;
                    dflt   = 255;
                end
                2: begin
                    cur_lo = 32767;
                    cur_hi = -32768;
                    cnt    = 3;
                    dflt   = 0;
                end
                3: begin
                    cur_lo = int'($urandom_range(0, 6000)) - 3000;
                    cur_hi = cur_lo;
                    cnt    = 2;
                end
                default: begin
                    cur_lo = int'($urandom_range(0, 6000)) - 3000;
                    cur_hi = clamp16(cur_lo + int'($urandom_range(0, 8000)) - 4000);
                    cnt    = (phase == 4) ? $urandom_range(5, 7) : $urandom_range(0, 7);
                end
            endcase
            for (i = 0; i < LEVEL_WORDS; i++) begin
                if (i > 0 && $urandom_range(0, 4) == 0)
                    w[i] = {w[i-1][23:8], 8'($urandom)};
                else if ($urandom_range(0, 9) == 0)
                    w[i] = level_word($urandom_range(0, 1) ? -32768 : 32767, $urandom);
                else
                    w[i] = level_word(pick_level(),
                                      ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 255));
            end
            apply_config(cur_lo, cur_hi, cnt, dflt, w[0], w[1], w[2], w[3]);

            // full-range phase runs with no idling on either side
            if (phase == 1) begin
                src_mode  = 1;
                sink_mode = 1;
            end
            // hold the receiver off while words keep coming, so the queue fills
            if (phase == 3) begin
                src_mode = 1;
                hold_requests <= hold_requests + 1;
            end

            target = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < target)
                random_row();
        end

        drain();
        if (fail_count == 0 && runs_waiting == 0)
            $display("heightmap_column_run_length_encoder_test: done, clean");
        else
            $display("heightmap_column_run_length_encoder_test: done, errors");
        $finish;
    end

endmodule
